[hw/rtl/linear_scan_priority_queue_unit_macros.svh]
// Assertion macros for the priority queue. Both sample on clk and stay
// quiet while rst_n is low.
`ifndef LINEAR_SCAN_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define LINEAR_SCAN_PRIORITY_QUEUE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSPQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/lspq_pkg.sv]
package lspq_pkg;

  // Field widths.
  localparam int ID_W  = 16;
  localparam int URG_W = 4;
  localparam int ST_W  = 2;
  localparam int OCC_W = 5;

  // Scan key: zero for an empty cell, urgency plus one for a live cell.
  localparam int KEY_W = URG_W + 1;

  // Operation codes.
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // Status codes.
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  // Control shared by every cell of the row.
  typedef struct packed {
    logic             scan;      // advance the running-maximum chain
    logic             compact;   // close the gap behind the winner
    logic [KEY_W-1:0] best_key;  // settled maximum key of the whole row
  } cell_ctl_t;

endpackage

[hw/rtl/lspq_if.sv]
// Request channel: operation plus the entry to insert.
interface lspq_in_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [lspq_pkg::ID_W-1:0]  document_id;
  logic [lspq_pkg::URG_W-1:0] urgency;

  modport source (output valid, operation, document_id, urgency, input ready);
  modport sink   (input valid, operation, document_id, urgency, output ready);
endinterface

// Result channel: one result per request.
interface lspq_out_if;
  logic                       valid;
  logic                       ready;
  logic [lspq_pkg::ID_W-1:0]  removed_id;
  logic [lspq_pkg::ST_W-1:0]  status;
  logic [lspq_pkg::OCC_W-1:0] occupancy_after;

  modport source (output valid, removed_id, status, occupancy_after, input ready);
  modport sink   (input valid, removed_id, status, occupancy_after, output ready);
endinterface

[hw/rtl/lspq_cell.sv]
// One queue slot. It holds an entry and one stage of the running-maximum
// chain that walks from the head toward the tail during a scan.
module lspq_cell (
  input  logic                          clk,
  input  lspq_pkg::cell_ctl_t           ctl,
  input  logic                          live,      // slot is below occupancy
  input  logic                          load_en,   // slot takes the new entry
  input  logic [lspq_pkg::ID_W-1:0]     load_id,
  input  logic [lspq_pkg::URG_W-1:0]    load_urg,
  input  logic [lspq_pkg::ID_W-1:0]     next_id,   // entry of the slot behind
  input  logic [lspq_pkg::URG_W-1:0]    next_urg,
  input  logic [lspq_pkg::KEY_W-1:0]    prev_key,  // running maximum ahead
  input  logic [lspq_pkg::ID_W-1:0]     prev_pid,
  output logic [lspq_pkg::ID_W-1:0]     id_o,
  output logic [lspq_pkg::URG_W-1:0]    urg_o,
  output logic [lspq_pkg::KEY_W-1:0]    key_o,
  output logic [lspq_pkg::ID_W-1:0]     pid_o
);

  logic [lspq_pkg::ID_W-1:0]  id_r, id_nxt;
  logic [lspq_pkg::URG_W-1:0] urg_r, urg_nxt;
  logic [lspq_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [lspq_pkg::ID_W-1:0]  pid_r, pid_nxt;
  logic [lspq_pkg::KEY_W-1:0] own_key;

  // A live slot bids urgency plus one, so any live entry beats an empty slot.
  assign own_key = live ? ({1'b0, urg_r} + lspq_pkg::KEY_W'(1)) : '0;

  // Running maximum. A strict compare keeps the earlier entry on a tie.
  always_comb begin
    key_nxt = key_r;
    pid_nxt = pid_r;
    if (ctl.scan) begin
      if (own_key > prev_key) begin
        key_nxt = own_key;
        pid_nxt = id_r;
      end else begin
        key_nxt = prev_key;
        pid_nxt = prev_pid;
      end
    end
  end

  // Entry update. The winner and every slot behind it take their successor,
  // which is exactly the set whose running maximum already equals the best.
  always_comb begin
    id_nxt  = id_r;
    urg_nxt = urg_r;
    if (load_en) begin
      id_nxt  = load_id;
      urg_nxt = load_urg;
    end else if (ctl.compact && (key_r == ctl.best_key)) begin
      id_nxt  = next_id;
      urg_nxt = next_urg;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    urg_r <= urg_nxt;
    key_r <= key_nxt;
    pid_r <= pid_nxt;
  end

  assign id_o  = id_r;
  assign urg_o = urg_r;
  assign key_o = key_r;
  assign pid_o = pid_r;

endmodule

[hw/rtl/linear_scan_priority_queue_unit.sv]
// An insert's result is registered in the cycle after its transfer. An extract on a
// non-empty queue runs a scan along the cell chain, then a compaction step that
// registers the result when the output is free. One request is worked on at a time.
// Throughput: one insert or empty extract per cycle while results are not stalled.
// Reset (rst_n low, synchronous) empties the queue; slot contents are not cleared.
`include "linear_scan_priority_queue_unit_macros.svh"

module linear_scan_priority_queue_unit #(
  parameter int DEPTH = 16
) (
  input logic        clk,
  input logic        rst_n,
  lspq_in_if.sink    in_ch,
  lspq_out_if.source out_ch
);

  localparam int ID_W  = lspq_pkg::ID_W;
  localparam int URG_W = lspq_pkg::URG_W;
  localparam int KEY_W = lspq_pkg::KEY_W;
  localparam int ST_W  = lspq_pkg::ST_W;
  localparam int OCC_W = lspq_pkg::OCC_W;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SCN_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [SCN_W-1:0]   scan_cnt_r, scan_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]    out_id_r, out_id_nxt;
  logic [ST_W-1:0]    out_st_r, out_st_nxt;
  logic [OCC_W-1:0]   out_occ_r, out_occ_nxt;

  logic               out_free;
  logic               in_xfer;
  logic               do_load;
  logic               do_scan;
  logic               do_compact;
  lspq_pkg::cell_ctl_t ctl;

  logic [ID_W-1:0]    cell_id  [DEPTH];
  logic [URG_W-1:0]   cell_urg [DEPTH];
  logic [KEY_W-1:0]   cell_key [DEPTH];
  logic [ID_W-1:0]    cell_pid [DEPTH];

  assign out_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_xfer    = in_ch.valid && in_ch.ready;
  assign do_load    = in_xfer && (in_ch.operation == lspq_pkg::OP_INSERT)
                      && (count_r < CNT_W'(DEPTH));
  assign do_scan    = in_xfer && (in_ch.operation == lspq_pkg::OP_EXTRACT)
                      && (count_r != '0);
  assign do_compact = (state_r == S_DONE) && out_free;

  assign ctl.scan     = (state_r == S_SCAN);
  assign ctl.compact  = do_compact;
  assign ctl.best_key = cell_key[DEPTH-1];

  // Row of slots; the running maximum enters at the head as an empty key.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_W-1:0]  nx_id;
    logic [URG_W-1:0] nx_urg;
    logic [KEY_W-1:0] pv_key;
    logic [ID_W-1:0]  pv_pid;

    if (i == DEPTH - 1) begin : g_tail
      assign nx_id  = cell_id[i];
      assign nx_urg = cell_urg[i];
    end else begin : g_body
      assign nx_id  = cell_id[i+1];
      assign nx_urg = cell_urg[i+1];
    end

    if (i == 0) begin : g_head
      assign pv_key = '0;
      assign pv_pid = '0;
    end else begin : g_link
      assign pv_key = cell_key[i-1];
      assign pv_pid = cell_pid[i-1];
    end

    lspq_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .live     (CNT_W'(i) < count_r),
      .load_en  (do_load && (count_r == CNT_W'(i))),
      .load_id  (in_ch.document_id),
      .load_urg (in_ch.urgency),
      .next_id  (nx_id),
      .next_urg (nx_urg),
      .prev_key (pv_key),
      .prev_pid (pv_pid),
      .id_o     (cell_id[i]),
      .urg_o    (cell_urg[i]),
      .key_o    (cell_key[i]),
      .pid_o    (cell_pid[i])
    );
  end

  // Sequencer and result register.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_cnt_nxt  = scan_cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_id_nxt    = out_id_r;
    out_st_nxt    = out_st_r;
    out_occ_nxt   = out_occ_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_ch.operation == lspq_pkg::OP_INSERT) begin
            out_valid_nxt = 1'b1;
            out_id_nxt    = '0;
            if (do_load) begin
              count_nxt   = count_r + CNT_W'(1);
              out_st_nxt  = lspq_pkg::ST_DONE;
              out_occ_nxt = OCC_W'(count_r + CNT_W'(1));
            end else begin
              out_st_nxt  = lspq_pkg::ST_FULL;
              out_occ_nxt = OCC_W'(count_r);
            end
          end else if (count_r == '0) begin
            out_valid_nxt = 1'b1;
            out_id_nxt    = '0;
            out_st_nxt    = lspq_pkg::ST_EMPTY;
            out_occ_nxt   = '0;
          end else begin
            scan_cnt_nxt = '0;
            state_nxt    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + SCN_W'(1);
        if (scan_cnt_r == SCN_W'(DEPTH - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (do_compact) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = cell_pid[DEPTH-1];
          out_st_nxt    = lspq_pkg::ST_DONE;
          out_occ_nxt   = OCC_W'(count_r - CNT_W'(1));
          count_nxt     = count_r - CNT_W'(1);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_id_r  <= out_id_nxt;
    out_st_r  <= out_st_nxt;
    out_occ_r <= out_occ_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.removed_id      = out_id_r;
  assign out_ch.status          = out_st_r;
  assign out_ch.occupancy_after = out_occ_r;

  // Checks on the queue's own bookkeeping.
  `LSPQ_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "occupancy above depth")
  `LSPQ_ASSERT_SAME(a_best_live, state_r == S_DONE, cell_key[DEPTH-1] != '0, "no winner found")
  `LSPQ_ASSERT_NEXT(a_insert_count, do_load, count_r == $past(count_r) + CNT_W'(1), "insert lost")
  `LSPQ_ASSERT_NEXT(a_extract_scan, do_scan, state_r == S_SCAN, "extract did not start a scan")

endmodule

[bench/linear_scan_priority_queue_unit_tb.sv]
module linear_scan_priority_queue_unit_tb;
  import lspq_pkg::*;

  localparam int QUEUE_DEPTH       = 16;
  localparam int HALF_PERIOD       = 5;
  localparam int RESET_CYCLES      = 10;
  localparam int REQUEST_TARGET    = 850;
  localparam int LONG_HOLD_CYCLES  = 120;
  localparam int SETTLE_CYCLES     = 2 * QUEUE_DEPTH + 8;
  localparam int TIMEOUT_CYCLES    = 400_000;
  localparam int MAX_PRINTED       = 40;

  // One result of the queue, as it appears on the result channel.
  typedef struct packed {
    logic [ID_W-1:0]  removed_id;
    logic [ST_W-1:0]  status;
    logic [OCC_W-1:0] occupancy_after;
  } queue_result_t;

  // One request, with an optional hand-written result for directed rows.
  typedef struct packed {
    logic             operation;
    logic [ID_W-1:0]  document_id;
    logic [URG_W-1:0] urgency;
    logic             has_known_result;
    queue_result_t    known_result;
  } request_t;

  // Flavors of random traffic.
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_TIES} traffic_mix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lspq_in_if  in_ch ();
  lspq_out_if out_ch ();

  linear_scan_priority_queue_unit #(
    .DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the queue contents, head first.
  logic [ID_W-1:0]  held_ids[$];
  logic [URG_W-1:0] held_urgencies[$];

  request_t      offered_requests[$];
  queue_result_t expected_results[$];

  int  failures = 0;
  int  requests_offered = 0;
  int  results_checked = 0;
  int  inserts_stored = 0;
  int  inserts_dropped = 0;
  int  extracts_served = 0;
  int  extracts_on_empty = 0;
  int  long_holds_done = 0;
  bit  long_hold_pending = 1'b0;

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("Timeout after %0d cycles, %0d results still pending",
             TIMEOUT_CYCLES, expected_results.size());
    $display("TEST FAILED");
    $finish;
  end

  // Prints one line per failure, up to a cap, and always counts it.
  task automatic report_failure(input string what);
    if (failures < MAX_PRINTED) begin
      $display("ERROR at %0t: %s", $time, what);
    end
    failures++;
  endtask

  // Applies one request to the shadow queue and returns the result it should give.
  function automatic queue_result_t serve_request(input request_t req);
    queue_result_t res;
    int            best;
    res = '0;
    res.status = ST_DONE;
    if (req.operation == OP_INSERT) begin
      if (held_ids.size() >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
        inserts_dropped++;
      end else begin
        held_ids.push_back(req.document_id);
        held_urgencies.push_back(req.urgency);
        inserts_stored++;
      end
    end else if (held_ids.size() == 0) begin
      res.status = ST_EMPTY;
      extracts_on_empty++;
    end else begin
      // Strictly greater keeps the earliest entry on equal urgency.
      best = 0;
      for (int i = 1; i < held_ids.size(); i++) begin
        if (held_urgencies[i] > held_urgencies[best]) begin
          best = i;
        end
      end
      res.removed_id = held_ids[best];
      held_ids.delete(best);
      held_urgencies.delete(best);
      extracts_served++;
    end
    res.occupancy_after = OCC_W'(held_ids.size());
    return res;
  endfunction

  function automatic request_t make_request(input logic op, input logic [ID_W-1:0] id,
                                            input logic [URG_W-1:0] urg,
                                            input logic known,
                                            input logic [ID_W-1:0] want_id,
                                            input logic [ST_W-1:0] want_status,
                                            input logic [OCC_W-1:0] want_occupancy);
    request_t req;
    req.operation = op;
    req.document_id = id;
    req.urgency = urg;
    req.has_known_result = known;
    req.known_result.removed_id = want_id;
    req.known_result.status = want_status;
    req.known_result.occupancy_after = want_occupancy;
    return req;
  endfunction

  function automatic request_t random_request(input traffic_mix_t mix);
    int               insert_pct;
    logic             op;
    logic [URG_W-1:0] urg;
    case (mix)
      MIX_FILL:  insert_pct = 85;
      MIX_DRAIN: insert_pct = 15;
      MIX_TIES:  insert_pct = 60;
      default:   insert_pct = 50;
    endcase
    op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_EXTRACT;
    // Tie-heavy traffic uses only the two extreme urgencies.
    if (mix == MIX_TIES) begin
      urg = URG_W'($urandom_range(0, 1) * 15);
    end else begin
      urg = URG_W'($urandom_range(0, 15));
    end
    return make_request(op, ID_W'($urandom_range(0, 65535)), urg, 1'b0, '0, ST_DONE, '0);
  endfunction

  // Presents one request and holds it until the transfer happens.
  task automatic send_request(input request_t req);
    offered_requests.push_back(req);
    in_ch.valid <= 1'b1;
    in_ch.operation <= req.operation;
    in_ch.document_id <= req.document_id;
    in_ch.urgency <= req.urgency;
    requests_offered++;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
  endtask

  task automatic idle_sender(input int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stops offering until every expected result has come back.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (offered_requests.size() != 0 || expected_results.size() != 0);
  endtask

  // Scoreboard: check result transfers, then predict for request transfers.
  always @(posedge clk) begin : scoreboard
    queue_result_t want;
    request_t      req;
    queue_result_t predicted;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          report_failure($sformatf("result with nothing pending: id %0h status %0d occ %0d",
                                   out_ch.removed_id, out_ch.status,
                                   out_ch.occupancy_after));
        end else begin
          want = expected_results.pop_front();
          if (out_ch.removed_id !== want.removed_id) begin
            report_failure($sformatf("removed_id got %0h expected %0h",
                                     out_ch.removed_id, want.removed_id));
          end
          if (out_ch.status !== want.status) begin
            report_failure($sformatf("status got %0d expected %0d",
                                     out_ch.status, want.status));
          end
          if (out_ch.occupancy_after !== want.occupancy_after) begin
            report_failure($sformatf("occupancy_after got %0d expected %0d",
                                     out_ch.occupancy_after, want.occupancy_after));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (offered_requests.size() == 0) begin
          report_failure("request transfer with no request offered");
        end else begin
          req = offered_requests.pop_front();
          predicted = serve_request(req);
          expected_results.push_back(req.has_known_result ? req.known_result : predicted);
        end
      end
    end
  end

  // Result side: random stall patterns, plus a long hold-off on request.
  initial begin : result_sink
    int hold_left;
    int pattern_left;
    int pattern_mode;
    hold_left = 0;
    pattern_left = 0;
    pattern_mode = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        long_holds_done++;
        hold_left = LONG_HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern_mode = $urandom_range(0, 2);
          pattern_left = $urandom_range(10, 60);
        end
        pattern_left--;
        case (pattern_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= ($urandom_range(0, 9) < 4);
        endcase
      end
    end
  end

  // Request side: reset, directed table, then random phases.
  initial begin : request_source
    request_t     directed_rows[$];
    traffic_mix_t mix;
    bit           gappy;
    int           phase;
    int           phase_len;
    int           burst_left;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_INSERT;
    in_ch.document_id = '0;
    in_ch.urgency = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty queue, both extremes of every field, then back to empty.
    directed_rows.push_back(make_request(OP_EXTRACT, '0, '0, 1'b1, '0, ST_EMPTY, '0));
    directed_rows.push_back(make_request(OP_INSERT, 16'h0000, 4'd0, 1'b1, '0, ST_DONE, 5'd1));
    directed_rows.push_back(make_request(OP_INSERT, 16'hFFFF, 4'd15, 1'b1, '0, ST_DONE, 5'd2));
    directed_rows.push_back(make_request(OP_EXTRACT, '0, '0, 1'b1, 16'hFFFF, ST_DONE, 5'd1));
    directed_rows.push_back(make_request(OP_EXTRACT, 16'hFFFF, 4'd15, 1'b1, 16'h0000, ST_DONE,
                                         5'd0));
    directed_rows.push_back(make_request(OP_EXTRACT, '0, '0, 1'b1, '0, ST_EMPTY, '0));
    // Fill to the brim with repeated urgencies so the next extract sees a tie.
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      directed_rows.push_back(make_request(OP_INSERT, ID_W'(16'h1111 * i + 16'h0A05),
                                           URG_W'(i % 3), i == QUEUE_DEPTH - 1, '0, ST_DONE,
                                           OCC_W'(QUEUE_DEPTH)));
    end
    directed_rows.push_back(make_request(OP_INSERT, 16'hBEEF, 4'd15, 1'b1, '0, ST_FULL,
                                         OCC_W'(QUEUE_DEPTH)));
    directed_rows.push_back(make_request(OP_EXTRACT, '0, '0, 1'b0, '0, ST_DONE, '0));
    directed_rows.push_back(make_request(OP_EXTRACT, '0, '0, 1'b0, '0, ST_DONE, '0));

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i]);
    end
    wait_for_results();

    // Random phases until the request budget is spent.
    phase = 0;
    while (requests_offered < REQUEST_TARGET) begin
      mix = traffic_mix_t'($urandom_range(0, 3));
      gappy = ($urandom_range(0, 2) != 0);
      phase_len = $urandom_range(20, 60);
      // A couple of phases push hard while the result side holds off.
      if (phase == 2 || phase == 11) begin
        long_hold_pending = 1'b1;
        mix = MIX_FILL;
        gappy = 1'b0;
      end
      burst_left = 0;
      for (int n = 0; n < phase_len; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          if (gappy && n != 0) begin
            idle_sender($urandom_range(1, 6));
          end
        end
        burst_left--;
        send_request(random_request(mix));
      end
      if (phase % 4 == 3) begin
        wait_for_results();
      end
      phase++;
    end

    // Let everything come back, then give the block time to misbehave.
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_failure($sformatf("%0d expected results never arrived", expected_results.size()));
    end

    $display("Covered %0d requests: %0d inserts stored, %0d dropped while full.",
             requests_offered, inserts_stored, inserts_dropped);
    $display("%0d extracts served, %0d on an empty queue, %0d results checked, %0d long holds.",
             extracts_served, extracts_on_empty, results_checked, long_holds_done);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/lspq_pkg.sv
hw/rtl/lspq_if.sv
hw/rtl/lspq_cell.sv
hw/rtl/linear_scan_priority_queue_unit.sv
bench/linear_scan_priority_queue_unit_tb.sv
